@@ rtl/pcbs_pkg.sv @@
// Shared types, command codes, register indices and reset values for the
// pulse-count backlight stepper. No dependencies.
package pcbs_pkg;

	localparam int unsigned HoldW  = 16;
	localparam int unsigned CfgIdxW = 3;

	// command codes on the control line
	localparam logic [1:0] ACT_LOW  = 2'd0;
	localparam logic [1:0] ACT_HIGH = 2'd1;
	localparam logic [1:0] ACT_WAIT = 2'd2;

	// register indices
	localparam logic [CfgIdxW-1:0] REG_MAX_LEVEL     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_UP_LOW_US     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DOWN_LOW_US   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PULSE_HIGH_US = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_OFF_HOLD_US   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ENABLE_HOLD_US = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SETTLE_US     = 3'd6;

	localparam logic [3:0]       RST_MAX_LEVEL      = 4'd15;
	localparam logic [HoldW-1:0] RST_UP_LOW_US      = 16'd30;
	localparam logic [HoldW-1:0] RST_DOWN_LOW_US    = 16'd250;
	localparam logic [HoldW-1:0] RST_PULSE_HIGH_US  = 16'd10;
	localparam logic [HoldW-1:0] RST_OFF_HOLD_US    = 16'd800;
	localparam logic [HoldW-1:0] RST_ENABLE_HOLD_US = 16'd5;
	localparam logic [HoldW-1:0] RST_SETTLE_US      = 16'd40000;

	localparam logic [4:0] RST_LEVEL     = 5'd6;
	localparam logic [4:0] ENABLED_LEVEL = 5'd16;

	typedef struct packed {
		logic [3:0]       max_level;
		logic [HoldW-1:0] up_low_us;
		logic [HoldW-1:0] down_low_us;
		logic [HoldW-1:0] pulse_high_us;
		logic [HoldW-1:0] off_hold_us;
		logic [HoldW-1:0] enable_hold_us;
		logic [HoldW-1:0] settle_us;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [HoldW-1:0] hold_us;
		logic             last_of_run;
	} cmd_t;

endpackage

@@ rtl/pcbs_req_if.sv @@
// Request channel: brightness level plus panel status flags.
// Stand-alone, no package dependency.
interface pcbs_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] level;
	logic       panel_on;
	logic       after_reinit;

	modport source (output valid, level, panel_on, after_reinit, input ready);
	modport sink   (input valid, level, panel_on, after_reinit, output ready);
endinterface

@@ rtl/pcbs_cmd_if.sv @@
// Command channel: one timed action for the backlight control line.
// Stand-alone, no package dependency.
interface pcbs_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] hold_us;
	logic        last_of_run;

	modport source (output valid, action, hold_us, last_of_run, input ready);
	modport sink   (input valid, action, hold_us, last_of_run, output ready);
endinterface

@@ rtl/pulse_count_backlight_stepper.sv @@
// Pulse-count backlight stepper: one request is taken when the sequencer is
// idle, then its commands leave one per cycle, while the sink does not stall,
// through a single output register (up to 32 commands: settle, enable and
// fifteen low/high pairs). The sequencer handles one request at a time; the
// next request may enter while the final command still waits to be taken.
// Registers are written through cfg_we / cfg_idx / cfg_data; unknown indices
// are ignored. Depends on pcbs_pkg, pcbs_req_if, pcbs_cmd_if and pcbs_seq.
module pulse_count_backlight_stepper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	pcbs_req_if.sink    req,
	pcbs_cmd_if.source  cmd
);
	import pcbs_pkg::*;

	cfg_t cfg_q;
	logic seq_idle;
	logic seq_valid;
	cmd_t seq_cmd;
	logic advance;
	logic out_valid_q;
	cmd_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_level      <= RST_MAX_LEVEL;
			cfg_q.up_low_us      <= RST_UP_LOW_US;
			cfg_q.down_low_us    <= RST_DOWN_LOW_US;
			cfg_q.pulse_high_us  <= RST_PULSE_HIGH_US;
			cfg_q.off_hold_us    <= RST_OFF_HOLD_US;
			cfg_q.enable_hold_us <= RST_ENABLE_HOLD_US;
			cfg_q.settle_us      <= RST_SETTLE_US;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_LEVEL:      cfg_q.max_level      <= cfg_data[3:0];
				REG_UP_LOW_US:      cfg_q.up_low_us      <= cfg_data;
				REG_DOWN_LOW_US:    cfg_q.down_low_us    <= cfg_data;
				REG_PULSE_HIGH_US:  cfg_q.pulse_high_us  <= cfg_data;
				REG_OFF_HOLD_US:    cfg_q.off_hold_us    <= cfg_data;
				REG_ENABLE_HOLD_US: cfg_q.enable_hold_us <= cfg_data;
				REG_SETTLE_US:      cfg_q.settle_us      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req.ready = seq_idle;
	// output slot is free when empty or being emptied this cycle
	assign advance   = !out_valid_q || cmd.ready;

	pcbs_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (req.valid),
		.level        (req.level),
		.panel_on     (req.panel_on),
		.after_reinit (req.after_reinit),
		.advance      (advance),
		.idle         (seq_idle),
		.cmd_valid    (seq_valid),
		.cmd          (seq_cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= seq_valid;
	end

	always_ff @(posedge clk) begin
		if (advance && seq_valid)
			out_q <= seq_cmd;
	end

	assign cmd.valid       = out_valid_q;
	assign cmd.action      = out_q.action;
	assign cmd.hold_us     = out_q.hold_us;
	assign cmd.last_of_run = out_q.last_of_run;

endmodule

@@ rtl/pcbs_seq.sv @@
// Command sequencer: keeps the current level, works out the step count for a
// request and walks off / settle / enable / step-pulse states one command at a time.
// Depends on pcbs_pkg.
module pcbs_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  pcbs_pkg::cfg_t    cfg,
	input  logic              start,
	input  logic [7:0]        level,
	input  logic              panel_on,
	input  logic              after_reinit,
	input  logic              advance,
	output logic              idle,
	output logic              cmd_valid,
	output pcbs_pkg::cmd_t    cmd
);
	import pcbs_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_OFF    = 3'd1;
	localparam logic [2:0] S_SETTLE = 3'd2;
	localparam logic [2:0] S_ENABLE = 3'd3;
	localparam logic [2:0] S_LOW    = 3'd4;
	localparam logic [2:0] S_HIGH   = 3'd5;

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic [4:0] cur_q;
	logic       en_q;
	logic       down_q;

	logic [3:0] req;
	logic [4:0] req5;
	logic [4:0] cur_eff;
	logic       go_down;
	logic [4:0] steps;
	logic       fire;

	assign req     = (level > {4'd0, cfg.max_level}) ? cfg.max_level : level[3:0];
	assign req5    = {1'b0, req};
	assign cur_eff = (cur_q == 5'd0) ? ENABLED_LEVEL : cur_q;
	assign go_down = req5 < cur_eff;
	assign steps   = go_down ? (cur_eff - req5) : (req5 - cur_eff);

	assign idle      = (state_q == S_IDLE);
	assign cmd_valid = !idle;
	assign fire      = cmd_valid && advance;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_OFF: begin
				cmd.action      = ACT_LOW;
				cmd.hold_us     = cfg.off_hold_us;
				cmd.last_of_run = 1'b1;
			end
			S_SETTLE: begin
				cmd.action      = ACT_WAIT;
				cmd.hold_us     = cfg.settle_us;
				cmd.last_of_run = !en_q && (cnt_q == 5'd0);
			end
			S_ENABLE: begin
				cmd.action      = ACT_HIGH;
				cmd.hold_us     = cfg.enable_hold_us;
				cmd.last_of_run = (cnt_q == 5'd0);
			end
			S_LOW: begin
				cmd.action      = ACT_LOW;
				cmd.hold_us     = down_q ? cfg.down_low_us : cfg.up_low_us;
				cmd.last_of_run = 1'b0;
			end
			S_HIGH: begin
				cmd.action      = ACT_HIGH;
				cmd.hold_us     = cfg.pulse_high_us;
				cmd.last_of_run = (cnt_q == 5'd1);
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 5'd0;
			cur_q   <= RST_LEVEL;
			en_q    <= 1'b0;
			down_q  <= 1'b0;
		end else if (idle) begin
			if (start) begin
				if (!panel_on) begin
					state_q <= S_OFF;
				end else if (req == 4'd0) begin
					state_q <= S_OFF;
					cur_q   <= 5'd0;
				end else begin
					cur_q  <= req5;
					cnt_q  <= steps;
					en_q   <= (cur_q == 5'd0);
					down_q <= go_down;
					if (after_reinit)
						state_q <= S_SETTLE;
					else if (cur_q == 5'd0)
						state_q <= S_ENABLE;
					else if (steps != 5'd0)
						state_q <= S_LOW;
					// same level and no settle: empty run
				end
			end
		end else if (fire) begin
			unique case (state_q)
				S_OFF: state_q <= S_IDLE;
				S_SETTLE: begin
					if (en_q)
						state_q <= S_ENABLE;
					else if (cnt_q != 5'd0)
						state_q <= S_LOW;
					else
						state_q <= S_IDLE;
				end
				S_ENABLE: state_q <= (cnt_q != 5'd0) ? S_LOW : S_IDLE;
				S_LOW:    state_q <= S_HIGH;
				S_HIGH: begin
					cnt_q   <= cnt_q - 5'd1;
					state_q <= (cnt_q == 5'd1) ? S_IDLE : S_LOW;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
